// File: hdl/crbu_pkg.sv
`default_nettype none

package crbu_pkg;

   localparam int DATA_BITS      = 32;
   localparam int FRAC_BITS      = 16;
   localparam int ROOT_BITS      = (DATA_BITS - 1 + 2 * FRAC_BITS) / 3 + 2;
   localparam int ROOT_MAG_BITS  = ROOT_BITS - 1;
   localparam int SQ_BITS        = 2 * ROOT_MAG_BITS;
   localparam int CUBE_BITS      = 3 * ROOT_MAG_BITS;
   localparam int BIT_IDX_BITS   = $clog2(ROOT_MAG_BITS);
   localparam int REQ_DATA_BITS  = ((DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((ROOT_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CUBE,
      ST_DECIDE,
      ST_RESULT
   } crbu_state_type;

   typedef struct packed {
      logic                    load;
      logic                    square;
      logic                    cube;
      logic                    decide;
      logic [BIT_IDX_BITS-1:0] bit_idx;
   } crbu_ctrl_type;

endpackage

`default_nettype wire

// File: hdl/crbu_mul.sv
`default_nettype none

module crbu_mul
   import crbu_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire logic [SQ_BITS-1:0]       mul_a,
   input  wire logic [ROOT_MAG_BITS-1:0] mul_b,
   output logic      [CUBE_BITS-1:0]     product_ff
);

   logic [CUBE_BITS-1:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/crbu_seq.sv
`default_nettype none

module crbu_seq
   import crbu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output crbu_ctrl_type ctrl
);

   crbu_state_type          state_ff;
   crbu_state_type          state_in;
   logic [BIT_IDX_BITS-1:0] bit_ff;
   logic [BIT_IDX_BITS-1:0] bit_in;
   logic                    last_bit;

   assign last_bit = (bit_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: state_in = ST_CUBE;
         ST_CUBE:   state_in = ST_DECIDE;
         ST_DECIDE: begin
            state_in = last_bit ? ST_RESULT : ST_SQUARE;
         end
         ST_RESULT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      ctrl.load    = 1'b0;
      ctrl.square  = 1'b0;
      ctrl.cube    = 1'b0;
      ctrl.decide  = 1'b0;
      ctrl.bit_idx = bit_ff;
      bit_in       = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctrl.load  = req_tvalid;
            bit_in     = BIT_IDX_BITS'(ROOT_MAG_BITS - 1);
         end
         ST_SQUARE: ctrl.square = 1'b1;
         ST_CUBE:   ctrl.cube   = 1'b1;
         ST_DECIDE: begin
            ctrl.decide = 1'b1;
            if (!last_bit) begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_RESULT: rsp_tvalid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=>
         (state_ff == ST_SQUARE && bit_ff == BIT_IDX_BITS'(ROOT_MAG_BITS - 1)))
      else $error("search did not start at the top bit");

   a_last_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && last_bit) |=> (state_ff == ST_RESULT))
      else $error("no result after the last bit");

   a_step_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUARE) |=> (state_ff == ST_CUBE))
      else $error("cube did not follow square");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

endmodule

`default_nettype wire

// File: hdl/cube_root_bisection_unit.sv
// search: rsp_tvalid rises after all 22 root bits are decided, each by a square, cube and decide step
// flow: no new transaction is taken until the result has been accepted; the shared 44x22 multiplier
//   computes square, then cube, of each trial value before one compare
// reset: synchronous, active high; clears the sequencer, no transaction in flight after it
`default_nettype none

module cube_root_bisection_unit
   import crbu_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,  // radicand
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata   // root, zero fill
);

   crbu_ctrl_type            ctrl;
   logic [DATA_BITS-1:0]     radicand;
   logic [DATA_BITS-1:0]     mag_ff;
   logic [DATA_BITS-1:0]     mag_in;
   logic                     neg_ff;
   logic                     neg_in;
   logic [ROOT_MAG_BITS-1:0] root_ff;
   logic [ROOT_MAG_BITS-1:0] root_in;
   logic [ROOT_MAG_BITS-1:0] trial;
   logic [SQ_BITS-1:0]       mul_a;
   logic [CUBE_BITS-1:0]     product;
   logic [CUBE_BITS-1:0]     target;
   logic                     fits;
   logic [ROOT_BITS-1:0]     root_pos;
   logic [ROOT_BITS-1:0]     root_out;

   crbu_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   assign trial = root_ff | (ROOT_MAG_BITS'(1) << ctrl.bit_idx);
   assign mul_a = ctrl.cube ? product[SQ_BITS-1:0] : SQ_BITS'(trial);

   crbu_mul u_mul (
      .clock      (clock),
      .enable     (ctrl.square | ctrl.cube),
      .mul_a      (mul_a),
      .mul_b      (trial),
      .product_ff (product)
   );

   assign radicand = req_tdata[DATA_BITS-1:0];
   assign target   = CUBE_BITS'({mag_ff, {(2 * FRAC_BITS){1'b0}}});
   assign fits     = (product <= target);

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      root_in = root_ff;
      if (ctrl.load) begin
         neg_in  = radicand[DATA_BITS-1];
         mag_in  = radicand[DATA_BITS-1] ? (~radicand + 1'b1) : radicand;
         root_in = '0;
      end else if (ctrl.decide && fits) begin
         root_in = trial;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      root_ff <= root_in;
   end

   assign root_pos  = {1'b0, root_ff};
   assign root_out  = neg_ff ? (ROOT_BITS'(0) - root_pos) : root_pos;
   assign rsp_tdata = RSP_DATA_BITS'(root_out);

endmodule

`default_nettype wire

// File: tb/tb_cube_root_bisection_unit.sv
`timescale 1ns / 1ps

module tb_cube_root_bisection_unit
   import crbu_pkg::*;
();

   localparam int RESET_CYCLES  = 12;
   localparam int HOLD_CYCLES   = 1500;
   localparam int WATCHDOG_MAX  = 8000;
   localparam int DRAIN_CYCLES  = 100;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // radicand
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // root, zero fill

   logic [ROOT_BITS-1:0] expected_roots[$];
   int error_count  = 0;
   int idle_cycles  = 0;
   bit sender_idle_on = 1'b1;
   bit rsp_idle_on    = 1'b1;
   bit hold_pending   = 1'b0;
   int hold_left      = 0;
   int stall_left     = 0;

   cube_root_bisection_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [ROOT_BITS-1:0] cube_root_q16(input logic [DATA_BITS-1:0] radicand);
      logic                 neg;
      logic [DATA_BITS-1:0] mag;
      logic [127:0]         target;
      logic [127:0]         cube;
      logic [63:0]          lo;
      logic [63:0]          hi;
      logic [63:0]          mid;
      logic [63:0]          one;
      logic [63:0]          signed_root;
      neg    = radicand[DATA_BITS-1];
      mag    = neg ? (~radicand + 1'b1) : radicand;
      one    = 64'd1 << FRAC_BITS;
      target = 128'(mag) << (2 * FRAC_BITS);
      lo     = '0;
      hi     = (64'(mag) > one) ? 64'(mag) : one;
      while (lo < hi) begin
         mid  = lo + (hi - lo + 64'd1) / 64'd2;
         cube = 128'(mid) * 128'(mid) * 128'(mid);
         if (cube <= target) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      signed_root = neg ? (64'd0 - lo) : lo;
      return signed_root[ROOT_BITS-1:0];
   endfunction

   function automatic logic [DATA_BITS-1:0] signed_from_mag(input logic [DATA_BITS-1:0] mag,
                                                           input bit neg);
      return neg ? (~mag + 1'b1) : mag;
   endfunction

   function automatic logic [DATA_BITS-1:0] random_radicand();
      logic [63:0]          trial_root;
      logic [63:0]          cube;
      logic [63:0]          mag;
      logic [DATA_BITS-1:0] value;
      bit                   neg;
      neg = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: value = $urandom;
         1: value = signed_from_mag($urandom_range(0, 65535), neg);
         2: begin
            // land on or next to a cube boundary
            trial_root = 64'($urandom_range(0, 2097152));
            cube       = trial_root * trial_root * trial_root;
            mag        = (cube + 64'hFFFF_FFFF) >> 32;
            mag        = mag + 64'($urandom_range(0, 2)) - 64'd1;
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            value      = signed_from_mag(mag[DATA_BITS-1:0], neg);
         end
         3: value = signed_from_mag($urandom_range(0, 32767) << FRAC_BITS, neg);
         4: value = signed_from_mag($urandom_range(0, 15), neg);
         default: value = signed_from_mag($urandom >> $urandom_range(0, 31), neg);
      endcase
      return value;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_radicand(input logic [DATA_BITS-1:0] value);
      int gap;
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      expected_roots.push_back(cube_root_q16(value));
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_pending) begin
         hold_left    = HOLD_CYCLES;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [ROOT_BITS-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_roots.size() == 0) begin
            $error("unexpected root transaction: %0d", $signed(rsp_tdata[ROOT_BITS-1:0]));
            error_count++;
         end else begin
            want = expected_roots.pop_front();
            if (rsp_tdata[ROOT_BITS-1:0] !== want) begin
               $error("root: expected %0d, actual %0d",
                      $signed(want), $signed(rsp_tdata[ROOT_BITS-1:0]));
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_MAX) begin
            $display("** cube_root_bisection_unit: FAILED **");
            $finish;
         end
      end
   end

   task automatic test_directed_values();
      logic [DATA_BITS-1:0] values [0:22];
      values = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000,
                 32'h0000_FFFF, 32'hFFFF_0001, 32'h0008_0000, 32'hFFF8_0000,
                 32'h001B_0000, 32'hFFE5_0000, 32'h0000_2000, 32'h0000_1FFF,
                 32'h0000_0040, 32'h7FFF_0000, 32'h8000_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h0001_0001, 32'h0007_FFFF};
      foreach (values[i]) send_radicand(values[i]);
   endtask

   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            sender_idle_on = $urandom_range(0, 3) != 0;
            rsp_idle_on    = $urandom_range(0, 3) != 0;
         end
         send_radicand(random_radicand());
      end
      sender_idle_on = 1'b1;
      rsp_idle_on    = 1'b1;
   endtask

   task automatic test_long_stall();
      hold_pending   = 1'b1;
      sender_idle_on = 1'b0;
      for (int i = 0; i < 8; i++) send_radicand(random_radicand());
      sender_idle_on = 1'b1;
   endtask

   task automatic test_back_to_back(input int count);
      sender_idle_on = 1'b0;
      rsp_idle_on    = 1'b0;
      for (int i = 0; i < count; i++) send_radicand(random_radicand());
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_values();
      test_random_traffic(1200);
      test_long_stall();
      test_random_traffic(200);
      test_back_to_back(320);
      req_tvalid <= 1'b0;
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** cube_root_bisection_unit: PASSED **");
      end else begin
         $display("** cube_root_bisection_unit: FAILED **");
      end
      $finish;
   end

endmodule
